@@ rtl/svm_pkg.sv @@
// Package with opcodes, status codes and shared types of the stack machine execute unit.
package svm_pkg;

    localparam int unsigned MemWordsDefault     = 4096;
    localparam int unsigned CodeAddrWidthDefault = 16;

    // Opcodes in mnemonic-table order.
    localparam logic [7:0] OP_LEA  = 8'd0;
    localparam logic [7:0] OP_IMM  = 8'd1;
    localparam logic [7:0] OP_JMP  = 8'd3;
    localparam logic [7:0] OP_CALL = 8'd4;
    localparam logic [7:0] OP_JZ   = 8'd5;
    localparam logic [7:0] OP_JNZ  = 8'd6;
    localparam logic [7:0] OP_ENT  = 8'd7;
    localparam logic [7:0] OP_ADJ  = 8'd8;
    localparam logic [7:0] OP_LEV  = 8'd9;
    localparam logic [7:0] OP_LI   = 8'd12;
    localparam logic [7:0] OP_LC   = 8'd13;
    localparam logic [7:0] OP_SI   = 8'd16;
    localparam logic [7:0] OP_SC   = 8'd17;
    localparam logic [7:0] OP_PUSH = 8'd21;
    localparam logic [7:0] OP_OR   = 8'd22;
    localparam logic [7:0] OP_XOR  = 8'd23;
    localparam logic [7:0] OP_AND  = 8'd24;
    localparam logic [7:0] OP_EQ   = 8'd26;
    localparam logic [7:0] OP_NE   = 8'd28;
    localparam logic [7:0] OP_LT   = 8'd30;
    localparam logic [7:0] OP_GT   = 8'd32;
    localparam logic [7:0] OP_LE   = 8'd34;
    localparam logic [7:0] OP_GE   = 8'd36;
    localparam logic [7:0] OP_SHL  = 8'd37;
    localparam logic [7:0] OP_SHR  = 8'd38;
    localparam logic [7:0] OP_ADD  = 8'd40;
    localparam logic [7:0] OP_SUB  = 8'd41;
    localparam logic [7:0] OP_MUL  = 8'd43;
    localparam logic [7:0] OP_DIV  = 8'd45;
    localparam logic [7:0] OP_MOD  = 8'd46;
    localparam logic [7:0] OP_NOP  = 8'd47;
    localparam logic [7:0] OP_EXIT = 8'd55;

    // Status codes.
    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_EXIT   = 2'd1;
    localparam logic [1:0] ST_DIVZ   = 2'd2;
    localparam logic [1:0] ST_UNSUPP = 2'd3;

    // Operation selects of the shared ALU.
    typedef enum logic [3:0] {
        ALU_OR, ALU_XOR, ALU_AND, ALU_EQ, ALU_NE, ALU_LT, ALU_GT, ALU_LE, ALU_GE,
        ALU_SHL, ALU_SHR, ALU_ADD, ALU_SUB, ALU_MUL
    } t_alu_op;

    // Control and status between sequencer and divider.
    typedef struct packed {
        logic start;
        logic want_rem;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ rtl/svm_ram.sv @@
// Generic single-port RAM with registered read.
module svm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle, write or read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/svm_alu.sv @@
// Shared arithmetic, logic, compare and shift unit with a registered result.
module svm_alu import svm_pkg::*; (
    input  logic        i_clk,
    input  t_alu_op     i_op,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    output logic [31:0] o_result
);

    logic [31:0] n_result;
    logic        w_lt;
    logic [4:0]  w_sh;

    assign w_lt = $signed(i_left) < $signed(i_right);
    assign w_sh = i_right[4:0];

    // Combinational operation select.
    always_comb begin
        case (i_op)
            ALU_OR:  n_result = i_left | i_right;
            ALU_XOR: n_result = i_left ^ i_right;
            ALU_AND: n_result = i_left & i_right;
            ALU_EQ:  n_result = {31'd0, i_left == i_right};
            ALU_NE:  n_result = {31'd0, i_left != i_right};
            ALU_LT:  n_result = {31'd0, w_lt};
            ALU_GT:  n_result = {31'd0, !w_lt && (i_left != i_right)};
            ALU_LE:  n_result = {31'd0, w_lt || (i_left == i_right)};
            ALU_GE:  n_result = {31'd0, !w_lt};
            ALU_SHL: n_result = i_left << w_sh;
            ALU_SHR: n_result = 32'($signed(i_left) >>> w_sh);
            ALU_ADD: n_result = i_left + i_right;
            ALU_SUB: n_result = i_left - i_right;
            ALU_MUL: n_result = 32'(i_left * i_right);
            default: n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

endmodule

@@ rtl/svm_div.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle.
module svm_div import svm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_ctl    i_ctl,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output t_div_sts    o_sts,
    output logic [31:0] o_result
);

    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic        r_negq, n_negq;
    logic        r_negr, n_negr;
    logic        r_want_rem, n_want_rem;
    logic [31:0] r_res, n_res;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    // Magnitude setup on start, one bit per cycle while busy.
    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0; n_quo = r_quo;
        n_rem = r_rem; n_dvs = r_dvs; n_negq = r_negq; n_negr = r_negr;
        n_want_rem = r_want_rem; n_res = r_res;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt = 6'd32;
            n_quo = i_dividend[31] ? 32'(-i_dividend) : i_dividend;
            n_dvs = i_divisor[31] ? 32'(-i_divisor) : i_divisor;
            n_rem = '0;
            n_negq = i_dividend[31] ^ i_divisor[31];
            n_negr = i_dividend[31];
            n_want_rem = i_ctl.want_rem;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial;
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_want_rem) begin
                    n_res = r_negr ? 32'(-n_rem[31:0]) : n_rem[31:0];
                end else begin
                    n_res = r_negq ? 32'(-n_quo) : n_quo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_dvs <= n_dvs;
        r_negq <= n_negq; r_negr <= n_negr; r_want_rem <= n_want_rem; r_res <= n_res;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_res;

    // The divider is never restarted while busy, and done follows the last step.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_count_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_ctl.start) |=> !r_busy) else $error("divider busy without start");

endmodule

@@ rtl/stack_vm_execute_unit.sv @@
// Top level of the stack machine execute unit: sequencer, memory, ALU and divider.
//
// Usage: one instruction (opcode, immediate, instr_addr) enters per input transaction
// on i_valid/o_stall. The result (next_pc, acc_value, status, exit_value) leaves as one
// output transaction on o_valid/i_stall. The unit works on one instruction at a time
// and raises o_stall from acceptance until the result register is free again.
// From acceptance to result valid, register-only instructions (IMM, LEA, jumps, ADJ,
// NOP, faults) pass only decode and done; PUSH, CALL and ENT add a memory write, a load
// or EXIT a read, a pop plus ALU op or SI a read and an execute or write step, LEV two
// reads, SC a read and a read-modify-write, DIV and MOD a read and the one-bit-per-cycle
// divider. Every memory access goes through the single port of the data memory, one word
// per cycle. A new instruction is accepted once the previous result has been taken.
// Reset (synchronous, active low) clears the accumulator, the frame base and the
// stack pointer (empty stack at the top of memory). Data memory is not cleared;
// reading a word never written returns unspecified data.
// When the receiver stalls, the result holds and no new instruction is taken.
module stack_vm_execute_unit import svm_pkg::*; #(
    parameter int unsigned MEM_WORDS       = MemWordsDefault,
    parameter int unsigned CODE_ADDR_WIDTH = CodeAddrWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_opcode,
    input  logic signed [31:0] i_immediate,
    input  logic [15:0] i_instr_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_next_pc,
    output logic signed [31:0] o_acc_value,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_exit_value
);

    localparam int unsigned WA = $clog2(MEM_WORDS);
    localparam int unsigned BA = WA + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POP1, S_POP1W, S_POP2, S_POP2W, S_EXEC, S_RMW,
        S_WRITE, S_DIV, S_DIVW, S_DONE
    } t_state;

    t_state          r_state;
    logic [31:0]     r_acc;
    logic [BA-1:0]   r_sp;
    logic [BA-1:0]   r_bp;
    logic [7:0]      r_op;
    logic [31:0]     r_imm;
    logic [CODE_ADDR_WIDTH-1:0] r_pc;
    logic [31:0]     r_l;
    logic [BA-1:0]   r_addr;
    logic            r_oval;
    logic [15:0]     r_onext;
    logic [1:0]      r_ostat;
    logic [31:0]     r_oexit;

    logic            w_we;
    logic [WA-1:0]   w_waddr;
    logic [31:0]     w_wdata;
    logic [31:0]     w_rdata;
    t_alu_op         w_aop;
    logic [31:0]     w_alu;
    t_div_ctl        w_dctl;
    t_div_sts        w_dsts;
    logic [31:0]     w_div;

    logic [CODE_ADDR_WIDTH-1:0] w_next, w_skip, w_tgt;
    logic [BA-1:0]   w_imm4;
    logic [BA-1:0]   w_lea;
    logic [4:0]      w_bsh;
    logic            w_accept;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_oval;
    assign w_next   = r_pc + 1'b1;
    assign w_skip   = r_pc + 2'd2;
    assign w_tgt    = r_imm[CODE_ADDR_WIDTH-1:0];
    assign w_imm4   = {r_imm[BA-3:0], 2'b00};
    assign w_lea    = r_bp + w_imm4;
    assign w_bsh    = {r_addr[1:0], 3'b000};

    // ALU select from the opcode.
    always_comb begin
        case (r_op)
            OP_OR:   w_aop = ALU_OR;
            OP_XOR:  w_aop = ALU_XOR;
            OP_AND:  w_aop = ALU_AND;
            OP_EQ:   w_aop = ALU_EQ;
            OP_NE:   w_aop = ALU_NE;
            OP_LT:   w_aop = ALU_LT;
            OP_GT:   w_aop = ALU_GT;
            OP_LE:   w_aop = ALU_LE;
            OP_GE:   w_aop = ALU_GE;
            OP_SHL:  w_aop = ALU_SHL;
            OP_SHR:  w_aop = ALU_SHR;
            OP_SUB:  w_aop = ALU_SUB;
            OP_MUL:  w_aop = ALU_MUL;
            default: w_aop = ALU_ADD;
        endcase
    end

    // The popped word comes straight from the memory port, so the ALU result
    // registered at the end of the pop-wait state (S_POP1W) is ready in the execute state.
    svm_alu u_alu (
        .i_clk(i_clk), .i_op(w_aop), .i_left(w_rdata), .i_right(r_acc), .o_result(w_alu)
    );

    assign w_dctl.start    = (r_state == S_DIV);
    assign w_dctl.want_rem = (r_op == OP_MOD);

    svm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl), .i_dividend(r_l),
        .i_divisor(r_acc), .o_sts(w_dsts), .o_result(w_div)
    );

    // Memory port: address and write data per state.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_sp[BA-1:2];
        w_wdata = r_acc;
        case (r_state)
            S_POP1: begin
                case (r_op)
                    OP_LI, OP_LC: w_waddr = r_addr[BA-1:2];
                    default: w_waddr = r_sp[BA-1:2];
                endcase
            end
            S_POP2: w_waddr = r_sp[BA-1:2];
            S_RMW: w_waddr = r_addr[BA-1:2];
            S_WRITE: begin
                w_we = 1'b1;
                case (r_op)
                    OP_CALL: begin
                        w_waddr = r_addr[BA-1:2];
                        w_wdata = 32'(w_skip);
                    end
                    OP_ENT: begin
                        w_waddr = r_addr[BA-1:2];
                        w_wdata = 32'(r_bp);
                    end
                    OP_SI: w_waddr = r_addr[BA-1:2];
                    OP_SC: begin
                        w_waddr = r_addr[BA-1:2];
                        w_wdata = (w_rdata & ~(32'hFF << w_bsh)) |
                                  ({24'd0, r_acc[7:0]} << w_bsh);
                    end
                    default: w_waddr = r_addr[BA-1:2];
                endcase
            end
            default: w_waddr = r_sp[BA-1:2];
        endcase
    end

    svm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_waddr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    // Sequencer, architectural state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_sp    <= '0;
            r_bp    <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_opcode;
                        r_imm   <= i_immediate;
                        r_pc    <= CODE_ADDR_WIDTH'(i_instr_addr);
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_ostat <= ST_RUN;
                    r_oexit <= '0;
                    r_onext <= 16'(w_next);
                    r_state <= S_DONE;
                    case (r_op)
                        OP_LEA: begin
                            r_acc   <= 32'(w_lea);
                            r_onext <= 16'(w_skip);
                        end
                        OP_IMM: begin
                            r_acc   <= r_imm;
                            r_onext <= 16'(w_skip);
                        end
                        OP_JMP: r_onext <= 16'(w_tgt);
                        OP_JZ:  r_onext <= 16'((r_acc == '0) ? w_tgt : w_skip);
                        OP_JNZ: r_onext <= 16'((r_acc != '0) ? w_tgt : w_skip);
                        OP_ADJ: begin
                            r_sp    <= r_sp + w_imm4;
                            r_onext <= 16'(w_skip);
                        end
                        OP_CALL, OP_ENT, OP_PUSH: begin
                            r_addr  <= r_sp - 3'd4;
                            r_sp    <= r_sp - 3'd4;
                            r_state <= S_WRITE;
                        end
                        OP_LEV: begin
                            r_sp    <= r_bp;
                            r_state <= S_POP1;
                        end
                        OP_LI, OP_LC: begin
                            r_addr  <= r_acc[BA-1:0];
                            r_state <= S_POP1;
                        end
                        OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT,
                        OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB,
                        OP_MUL: r_state <= S_POP1;
                        OP_DIV, OP_MOD: begin
                            if (r_acc == '0) begin
                                r_ostat <= ST_DIVZ;
                                r_onext <= 16'(r_pc);
                            end else begin
                                r_state <= S_POP1;
                            end
                        end
                        OP_EXIT: begin
                            r_ostat <= ST_EXIT;
                            r_onext <= 16'(r_pc);
                            r_state <= S_POP1;
                        end
                        OP_NOP: ;
                        default: begin
                            r_ostat <= ST_UNSUPP;
                            r_onext <= 16'(r_pc);
                        end
                    endcase
                end
                S_POP1: r_state <= S_POP1W;
                S_POP1W: begin
                    r_l     <= w_rdata;
                    r_state <= S_EXEC;
                    case (r_op)
                        OP_LI: begin
                            r_acc   <= w_rdata;
                            r_state <= S_DONE;
                        end
                        OP_LC: begin
                            r_acc   <= 32'($signed(8'(w_rdata >> w_bsh)));
                            r_state <= S_DONE;
                        end
                        OP_EXIT: begin
                            r_oexit <= w_rdata;
                            r_state <= S_DONE;
                        end
                        OP_LEV: begin
                            r_bp    <= w_rdata[BA-1:0];
                            r_sp    <= r_sp + 3'd4;
                            r_state <= S_POP2;
                        end
                        OP_SI, OP_SC: begin
                            r_addr  <= w_rdata[BA-1:0];
                            r_sp    <= r_sp + 3'd4;
                            r_state <= (r_op == OP_SC) ? S_RMW : S_WRITE;
                        end
                        OP_DIV, OP_MOD: begin
                            r_sp    <= r_sp + 3'd4;
                            r_state <= S_DIV;
                        end
                        default: r_sp <= r_sp + 3'd4;
                    endcase
                end
                S_POP2: r_state <= S_POP2W;
                S_POP2W: begin
                    r_onext <= 16'(w_rdata[CODE_ADDR_WIDTH-1:0]);
                    r_sp    <= r_sp + 3'd4;
                    r_state <= S_DONE;
                end
                S_EXEC: begin
                    r_acc   <= w_alu;
                    r_state <= S_DONE;
                end
                S_RMW: r_state <= S_WRITE;
                S_WRITE: begin
                    if (r_op == OP_SC) begin
                        r_acc <= 32'($signed(r_acc[7:0]));
                    end
                    if (r_op == OP_ENT) begin
                        r_bp <= r_sp;
                        r_sp <= r_sp - w_imm4;
                    end
                    if (r_op == OP_CALL) begin
                        r_onext <= 16'(w_tgt);
                    end
                    if (r_op == OP_ENT) begin
                        r_onext <= 16'(w_skip);
                    end
                    r_state <= S_DONE;
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_dsts.done) begin
                        r_acc   <= w_div;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_oval  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_oval;
    assign o_next_pc    = r_onext;
    assign o_acc_value  = r_acc;
    assign o_status     = r_ostat;
    assign o_exit_value = r_oexit;

    // Nothing is accepted while an instruction or its result is pending.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_oval) |-> $past(r_state == S_DONE)) else $error("result without done");
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECODE)) else $error("accept not decoded");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we) else $error("memory write while idle");

endmodule
